@@ src/kwm_pkg.sv @@
package kwm_pkg;

	localparam int MAX_SOURCES = 256;
	localparam int IDX_W       = $clog2(MAX_SOURCES);
	localparam int CNT_W       = IDX_W + 1;
	localparam int CH_W        = IDX_W + 2;
	localparam int SRC_W       = 8;
	localparam int TS_W        = 32;
	localparam int ID_W        = 32;
	localparam int KEY_W       = TS_W + SRC_W;
	localparam int PAY_W       = 2 * ID_W;

	localparam logic REQ_PUSH = 1'b0;
	localparam logic REQ_POP  = 1'b1;

	typedef logic [KEY_W-1:0] key_t;
	typedef logic [IDX_W-1:0] idx_t;

	typedef struct packed {
		logic en;
		idx_t addr;
		key_t key;
	} key_wr_t;

	typedef struct packed {
		idx_t addr_a;
		idx_t addr_b;
	} key_rd_t;

endpackage

@@ src/kwm_if.sv @@
interface kwm_req_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [7:0]  source;
	logic signed [31:0] timestamp;
	logic [31:0] store_id;
	logic [31:0] user_id;

	modport src (output valid, req_type, source, timestamp, store_id, user_id, input ready);
	modport snk (input valid, req_type, source, timestamp, store_id, user_id, output ready);
endinterface

interface kwm_rsp_if;
	logic        valid;
	logic        ready;
	logic signed [31:0] out_timestamp;
	logic [31:0] out_store_id;
	logic [31:0] out_user_id;
	logic [7:0]  out_source;
	logic        heap_empty;
	logic        push_error;

	modport src (output valid, out_timestamp, out_store_id, out_user_id, out_source,
		heap_empty, push_error, input ready);
	modport snk (input valid, out_timestamp, out_store_id, out_user_id, out_source,
		heap_empty, push_error, output ready);
endinterface

@@ src/kwm_key_ram.sv @@
module kwm_key_ram (
	input  logic             clk,
	input  kwm_pkg::key_wr_t wr,
	input  kwm_pkg::key_rd_t rd,
	output kwm_pkg::key_t    rd_key_a,
	output kwm_pkg::key_t    rd_key_b
);

	kwm_pkg::key_t mem [kwm_pkg::MAX_SOURCES];
	kwm_pkg::key_t rd_a_q;
	kwm_pkg::key_t rd_b_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.key;
		end
		rd_a_q <= mem[rd.addr_a];
		rd_b_q <= mem[rd.addr_b];
	end

	assign rd_key_a = rd_a_q;
	assign rd_key_b = rd_b_q;

endmodule

@@ src/k_way_merge_by_timestamp.sv @@
// k_way_merge_by_timestamp: min-heap merge of up to MAX_SOURCES sorted runs.
// Channel req (kwm_req_if, sink side) carries one transaction per request:
// req_type push inserts the head record of run 'source', req_type pop removes
// the record with the smallest timestamp (ties to the lower source).
// Channel rsp (kwm_rsp_if, source side) carries one transaction per pop, none
// per push. A pop on an empty heap returns heap_empty with zero fields.
// push_error is sticky: a push for a source already held, or with a full
// heap, is dropped and flags it on every later pop until reset.
// One request is worked on at a time; req.ready is high while idle.
// A push climbs the heap through S_UP_RD and S_UP_CMP, level by level.
// A pop reads keys in S_POP_RD and S_POP_KEY, loads its result into the output
// register in S_POP_PAY, then restores the heap through S_DN_RD and S_DN_CMP,
// level by level; each level waits for the key memory's registered read.
// If rsp stalls, a finished result waits in the output register; a further
// request is still taken, and a second pop result waits until the first
// is taken. arst_n clears the heap count, presence bits and sticky error;
// key and payload memories are not cleared.
module k_way_merge_by_timestamp (
	input  logic          clk,
	input  logic          arst_n,
	kwm_req_if.snk        req,
	kwm_rsp_if.src        rsp
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_EMPTY,
		S_UP_RD,
		S_UP_CMP,
		S_POP_RD,
		S_POP_KEY,
		S_POP_PAY,
		S_DN_RD,
		S_DN_CMP
	} state_t;

	state_t state_q;

	logic [kwm_pkg::CNT_W-1:0]       count_q;
	logic                            err_q;
	logic [kwm_pkg::MAX_SOURCES-1:0] present_q;
	kwm_pkg::idx_t                   hole_q;
	kwm_pkg::key_t                   cur_key_q;
	kwm_pkg::key_t                   root_q;

	logic                            rsp_valid_q;
	logic [31:0]                     rsp_ts_q;
	logic [31:0]                     rsp_store_q;
	logic [31:0]                     rsp_user_q;
	logic [7:0]                      rsp_src_q;
	logic                            rsp_empty_q;
	logic                            rsp_err_q;

	logic [kwm_pkg::PAY_W-1:0]       pay_mem [kwm_pkg::MAX_SOURCES];
	logic [kwm_pkg::PAY_W-1:0]       pay_rdata_q;

	kwm_pkg::key_wr_t key_wr;
	kwm_pkg::key_rd_t key_rd;
	kwm_pkg::key_t    rd_key_a;
	kwm_pkg::key_t    rd_key_b;

	logic                      req_fire;
	logic                      out_free;
	logic                      rsp_load;
	kwm_pkg::idx_t             src_idx;
	logic                      push_bad;
	kwm_pkg::key_t             new_key;
	kwm_pkg::idx_t             parent;
	logic [kwm_pkg::CH_W-1:0]  lch;
	logic [kwm_pkg::CH_W-1:0]  rch;
	logic                      l_ok;
	logic                      r_ok;
	logic                      take_l;
	logic                      take_r;
	kwm_pkg::key_t             min_lk;
	kwm_pkg::idx_t             pay_raddr;

	assign req.ready = (state_q == S_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign out_free  = !rsp_valid_q || rsp.ready;
	assign rsp_load  = ((state_q == S_EMPTY) || (state_q == S_POP_PAY)) && out_free;

	assign src_idx  = kwm_pkg::IDX_W'(req.source);
	assign push_bad = (32'(req.source) >= 32'(kwm_pkg::MAX_SOURCES))
		|| (count_q >= kwm_pkg::CNT_W'(kwm_pkg::MAX_SOURCES))
		|| present_q[src_idx];
	assign new_key  = {~req.timestamp[31], req.timestamp[30:0], req.source};

	assign parent = (hole_q - 1'b1) >> 1;
	assign lch    = {1'b0, hole_q, 1'b1};
	assign rch    = lch + 1'b1;
	assign l_ok   = lch < kwm_pkg::CH_W'(count_q);
	assign r_ok   = rch < kwm_pkg::CH_W'(count_q);
	assign take_l = l_ok && (rd_key_a < cur_key_q);
	assign min_lk = take_l ? rd_key_a : cur_key_q;
	assign take_r = r_ok && (rd_key_b < min_lk);

	assign pay_raddr = (state_q == S_POP_KEY) ? kwm_pkg::IDX_W'(rd_key_a[7:0])
		: kwm_pkg::IDX_W'(root_q[7:0]);

	always_comb begin
		key_wr = '0;
		key_rd = '0;
		unique case (state_q)
			S_UP_RD: begin
				if (hole_q == '0) begin
					key_wr = '{en: 1'b1, addr: hole_q, key: cur_key_q};
				end else begin
					key_rd.addr_a = parent;
				end
			end
			S_UP_CMP: begin
				if (cur_key_q < rd_key_a) begin
					key_wr = '{en: 1'b1, addr: hole_q, key: rd_key_a};
				end else begin
					key_wr = '{en: 1'b1, addr: hole_q, key: cur_key_q};
				end
			end
			S_POP_RD: begin
				key_rd.addr_a = '0;
				key_rd.addr_b = kwm_pkg::IDX_W'(count_q - 1'b1);
			end
			S_DN_RD: begin
				if (!l_ok) begin
					key_wr = '{en: 1'b1, addr: hole_q, key: cur_key_q};
				end else begin
					key_rd.addr_a = kwm_pkg::IDX_W'(lch);
					key_rd.addr_b = kwm_pkg::IDX_W'(rch);
				end
			end
			S_DN_CMP: begin
				if (take_r) begin
					key_wr = '{en: 1'b1, addr: hole_q, key: rd_key_b};
				end else if (take_l) begin
					key_wr = '{en: 1'b1, addr: hole_q, key: rd_key_a};
				end else begin
					key_wr = '{en: 1'b1, addr: hole_q, key: cur_key_q};
				end
			end
			default: begin
				key_wr = '0;
			end
		endcase
	end

	kwm_key_ram u_key_ram (
		.clk      (clk),
		.wr       (key_wr),
		.rd       (key_rd),
		.rd_key_a (rd_key_a),
		.rd_key_b (rd_key_b)
	);

	always_ff @(posedge clk) begin
		if (req_fire && req.req_type == kwm_pkg::REQ_PUSH && !push_bad) begin
			pay_mem[src_idx] <= {req.store_id, req.user_id};
		end
		pay_rdata_q <= pay_mem[pay_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			err_q       <= 1'b0;
			present_q   <= '0;
			hole_q      <= '0;
			cur_key_q   <= '0;
			root_q      <= '0;
			rsp_valid_q <= 1'b0;
			rsp_ts_q    <= '0;
			rsp_store_q <= '0;
			rsp_user_q  <= '0;
			rsp_src_q   <= '0;
			rsp_empty_q <= 1'b0;
			rsp_err_q   <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						if (req.req_type == kwm_pkg::REQ_PUSH) begin
							if (push_bad) begin
								err_q <= 1'b1;
							end else begin
								present_q[src_idx] <= 1'b1;
								cur_key_q          <= new_key;
								hole_q             <= kwm_pkg::IDX_W'(count_q);
								count_q            <= count_q + 1'b1;
								state_q            <= S_UP_RD;
							end
						end else if (count_q == '0) begin
							state_q <= S_EMPTY;
						end else begin
							state_q <= S_POP_RD;
						end
					end
				end
				S_EMPTY: begin
					if (out_free) begin
						rsp_ts_q    <= '0;
						rsp_store_q <= '0;
						rsp_user_q  <= '0;
						rsp_src_q   <= '0;
						rsp_empty_q <= 1'b1;
						rsp_err_q   <= err_q;
						state_q     <= S_IDLE;
					end
				end
				S_UP_RD: begin
					state_q <= (hole_q == '0) ? S_IDLE : S_UP_CMP;
				end
				S_UP_CMP: begin
					if (cur_key_q < rd_key_a) begin
						hole_q  <= parent;
						state_q <= S_UP_RD;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_POP_RD: begin
					state_q <= S_POP_KEY;
				end
				S_POP_KEY: begin
					root_q    <= rd_key_a;
					cur_key_q <= rd_key_b;
					hole_q    <= '0;
					count_q   <= count_q - 1'b1;
					present_q[kwm_pkg::IDX_W'(rd_key_a[7:0])] <= 1'b0;
					state_q   <= S_POP_PAY;
				end
				S_POP_PAY: begin
					if (out_free) begin
						rsp_ts_q    <= {~root_q[kwm_pkg::KEY_W-1], root_q[kwm_pkg::KEY_W-2:8]};
						rsp_store_q <= pay_rdata_q[63:32];
						rsp_user_q  <= pay_rdata_q[31:0];
						rsp_src_q   <= root_q[7:0];
						rsp_empty_q <= 1'b0;
						rsp_err_q   <= err_q;
						state_q     <= S_DN_RD;
					end
				end
				S_DN_RD: begin
					state_q <= l_ok ? S_DN_CMP : S_IDLE;
				end
				S_DN_CMP: begin
					if (take_r) begin
						hole_q  <= kwm_pkg::IDX_W'(rch);
						state_q <= S_DN_RD;
					end else if (take_l) begin
						hole_q  <= kwm_pkg::IDX_W'(lch);
						state_q <= S_DN_RD;
					end else begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.out_timestamp = rsp_ts_q;
	assign rsp.out_store_id  = rsp_store_q;
	assign rsp.out_user_id   = rsp_user_q;
	assign rsp.out_source    = rsp_src_q;
	assign rsp.heap_empty    = rsp_empty_q;
	assign rsp.push_error    = rsp_err_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= kwm_pkg::CNT_W'(kwm_pkg::MAX_SOURCES))
		else $error("heap count beyond capacity");

	a_present_matches_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> $countones(present_q) == 32'(count_q))
		else $error("presence bits disagree with heap count");

	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		err_q |=> err_q)
		else $error("sticky push error cleared");

	a_empty_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_empty_q |-> rsp_ts_q == '0 && rsp_src_q == '0)
		else $error("empty pop result carries a record");

endmodule
